// ----- rtl/cic_pkg.sv -----
`default_nettype none
package cic_pkg;

  // Source counts and the position of the secondary summary line
  localparam int unsigned SecSources = 32;
  localparam int unsigned PriSources = 32;
  localparam int unsigned AggBit     = 14;

  localparam int unsigned IrqCount = SecSources + PriSources;
  localparam int unsigned PriBase  = SecSources;

  localparam logic [31:0] SecUsed  = 32'((64'd1 << SecSources) - 64'd1);
  localparam logic [31:0] AggMask  = 32'(64'd1 << AggBit);
  localparam logic [31:0] LineUsed = 32'((64'd1 << PriSources) - 64'd1) | AggMask;

  localparam int unsigned InDataW  = 80;
  localparam int unsigned OutDataW = 8;

  typedef enum logic [1:0] {
    OpEnable  = 2'd0,
    OpDisable = 2'd1,
    OpAck     = 2'd2,
    OpUpdate  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StRange   = 2'd1,
    StNone    = 2'd2
  } status_e;

  typedef struct packed {
    op_e         opcode;
    logic [6:0]  irq_number;
    logic [31:0] primary_lines;
    logic [31:0] secondary_raise;
  } req_t;

  typedef struct packed {
    status_e     status;
    logic [5:0]  irq_out;
  } rsp_t;

endpackage
`default_nettype wire

// ----- rtl/cic_prio.sv -----
`default_nettype none
// Highest set bit of a 32-bit vector; zero when nothing is set.
module cic_prio (
  input  logic [31:0] vec_i,
  output logic [4:0]  idx_o
);

  always_comb begin
    idx_o = '0;
    for (int i = 0; i < 32; i++) begin
      if (vec_i[i]) begin
        idx_o = 5'(i);
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/cic_core.sv -----
`default_nettype none
// Mask and flag state plus the per-item update and acknowledge logic.
module cic_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            fire_i,
  input  cic_pkg::req_t   req_i,
  output cic_pkg::rsp_t   rsp_o
);

  logic [31:0] sec_mask_q, sec_mask_d;
  logic [31:0] sec_flags_q, sec_flags_d;
  logic [31:0] pri_mask_q, pri_mask_d;

  logic [31:0] flags_raised;
  logic [31:0] cause;
  logic [31:0] pend;
  logic [31:0] pri_cause;
  logic        agg_on;
  logic        sec_hit;
  logic [4:0]  sec_idx;
  logic [4:0]  pri_idx;
  logic [6:0]  pri_num;
  logic [31:0] sec_bit;
  logic [31:0] pri_bit;

  cic_prio u_sec_prio (
    .vec_i (pend),
    .idx_o (sec_idx)
  );

  cic_prio u_pri_prio (
    .vec_i (pri_cause),
    .idx_o (pri_idx)
  );

  always_comb begin
    flags_raised = sec_flags_q | (req_i.secondary_raise & cic_pkg::SecUsed);
    cause        = req_i.primary_lines & cic_pkg::LineUsed & pri_mask_q;
    agg_on       = (cause & cic_pkg::AggMask) != '0;
    pend         = flags_raised & sec_mask_q;
    sec_hit      = agg_on && (pend != '0);
    // Drop the summary line when no secondary source stands behind it
    pri_cause    = (agg_on && !sec_hit) ? (cause & ~cic_pkg::AggMask) : cause;
    pri_num      = req_i.irq_number - 7'(cic_pkg::PriBase);
    sec_bit      = 32'(1) << req_i.irq_number[4:0];
    pri_bit      = 32'(1) << pri_num[4:0];

    sec_mask_d    = sec_mask_q;
    sec_flags_d   = flags_raised;
    pri_mask_d    = pri_mask_q;
    rsp_o.status  = cic_pkg::StOk;
    rsp_o.irq_out = '0;

    case (req_i.opcode) inside
      cic_pkg::OpEnable, cic_pkg::OpDisable: begin
        if (req_i.irq_number >= 7'(cic_pkg::IrqCount)) begin
          rsp_o.status = cic_pkg::StRange;
        end else if (req_i.irq_number < 7'(cic_pkg::PriBase)) begin
          sec_mask_d = (req_i.opcode == cic_pkg::OpEnable) ? (sec_mask_q | sec_bit)
                                                           : (sec_mask_q & ~sec_bit);
        end else begin
          pri_mask_d = (req_i.opcode == cic_pkg::OpEnable) ? (pri_mask_q | pri_bit)
                                                           : (pri_mask_q & ~pri_bit);
        end
      end
      cic_pkg::OpAck: begin
        if (sec_hit) begin
          sec_flags_d   = flags_raised & ~(32'(1) << sec_idx);
          rsp_o.irq_out = 6'(sec_idx);
        end else if (pri_cause == '0) begin
          rsp_o.status = cic_pkg::StNone;
        end else begin
          rsp_o.irq_out = 6'(cic_pkg::PriBase) + 6'(pri_idx);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sec_mask_q  <= '0;
      sec_flags_q <= '0;
      pri_mask_q  <= cic_pkg::AggMask;
    end else if (fire_i) begin
      sec_mask_q  <= sec_mask_d;
      sec_flags_q <= sec_flags_d;
      pri_mask_q  <= pri_mask_d;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/cascaded_interrupt_controller.sv -----
`default_nettype none
// Channel    Dir  Handshake                    Payload (lowest bit up)
// s_axis     in   s_axis_tvalid/s_axis_tready  opcode[1:0] irq_number[8:2]
//                                              primary_lines[40:9]
//                                              secondary_raise[72:41], zero[79:73]
// m_axis     out  m_axis_tvalid/m_axis_tready  status[1:0] irq_out[7:2]
//
// One item per cycle sustained while m_axis_tready stays high; an accepted item
// passes through the input register, then the result register, which drives m_axis.
// Mask/flag update and both priority encoders sit between the two registers,
// so the next item sees the updated state right away.
// Reset: secondary mask and flags cleared, primary mask holds only the summary bit.
// A stalled output holds its result; the input stalls once the input register is full and cannot advance.
module cascaded_interrupt_controller (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // opcode, irq_number, primary_lines, secondary_raise, zero padding
  input  logic [cic_pkg::InDataW-1:0]  s_axis_tdata,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // status, irq_out
  output logic [cic_pkg::OutDataW-1:0] m_axis_tdata
);

  logic          in_vld_q;
  cic_pkg::req_t req_q;
  logic          out_vld_q;
  cic_pkg::rsp_t rsp_q;
  cic_pkg::rsp_t rsp_d;
  logic          advance;
  logic          in_take;

  // Move the held item into the result register when the result slot frees
  assign advance       = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  cic_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (advance),
    .req_i  (req_q),
    .rsp_o  (rsp_d)
  );

  // Input register: valid bit under reset, payload loads on accept
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_take) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      req_q.opcode          <= cic_pkg::op_e'(s_axis_tdata[1:0]);
      req_q.irq_number      <= s_axis_tdata[8:2];
      req_q.primary_lines   <= s_axis_tdata[40:9];
      req_q.secondary_raise <= s_axis_tdata[72:41];
    end
  end

  // Result register: hold until the sink takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      rsp_q <= rsp_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {rsp_q.irq_out, rsp_q.status};

endmodule
`default_nettype wire

// ----- sim/cic_checker.sv -----
module cic_checker
  import cic_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  // opcode, irq_number, primary_lines, secondary_raise, zero padding
  input  logic [79:0] s_tdata_i,
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  // status, irq_out
  input  logic [7:0]  m_tdata_i,
  output int          fail_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [31:0] sec_mask  = '0;
  logic [31:0] sec_flags = '0;
  logic [31:0] pri_mask  = AggMask;

  rsp_t predicted_answers[$];

  initial fail_count_o = 0;
  initial pending_o = 0;

  function automatic int highest_set(input logic [31:0] v);
    int msb;
    msb = 0;
    for (int i = 31; i >= 0; i--) begin
      if (v[i] && msb == 0) msb = i;
    end
    return msb;
  endfunction

  // Advance the controller state by one request and return its answer.
  function automatic rsp_t resolve_irq_request(input op_e op, input logic [6:0] irq,
                                               input logic [31:0] lines,
                                               input logic [31:0] raise);
    rsp_t        ans;
    logic [31:0] cause;
    logic [31:0] pend;
    logic [31:0] sel;
    int          msb;
    logic        taken;
    ans.status  = StOk;
    ans.irq_out = '0;
    taken       = 1'b0;
    sec_flags   = sec_flags | (raise & SecUsed);
    case (op)
      OpEnable, OpDisable: begin
        if (irq >= IrqCount) begin
          ans.status = StRange;
        end else if (irq < PriBase) begin
          sel = 32'd1 << irq;
          sec_mask = (op == OpEnable) ? (sec_mask | sel) : (sec_mask & ~sel);
        end else begin
          sel = 32'd1 << (irq - PriBase);
          pri_mask = (op == OpEnable) ? (pri_mask | sel) : (pri_mask & ~sel);
        end
      end
      OpAck: begin
        cause = lines & LineUsed & pri_mask;
        if ((cause & AggMask) != '0) begin
          pend = sec_flags & sec_mask;
          if (pend != '0) begin
            msb = highest_set(pend);
            sec_flags[msb] = 1'b0;
            ans.irq_out = 6'(msb);
            taken = 1'b1;
          end else begin
            // summary line up with nothing unmasked behind it: drop it
            cause = cause & ~AggMask;
          end
        end
        if (!taken) begin
          if (cause == '0) ans.status = StNone;
          else ans.irq_out = 6'(PriBase + highest_set(cause));
        end
      end
      default: ;
    endcase
    return ans;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    rsp_t want;
    if (!rst_ni) begin
      sec_mask  = '0;
      sec_flags = '0;
      pri_mask  = AggMask;
      predicted_answers.delete();
      pending_o = 0;
    end else begin
      // compare first: an item accepted now cannot answer in this cycle
      if (m_tvalid_i && m_tready_i) begin
        if (predicted_answers.size() == 0) begin
          $error("answer item %h arrived with nothing expected", m_tdata_i);
          fail_count_o = fail_count_o + 1;
        end else begin
          want = predicted_answers.pop_front();
          if (m_tdata_i[1:0] !== want.status) begin
            $error("status mismatch: expected %0d, got %0d", want.status, m_tdata_i[1:0]);
            fail_count_o = fail_count_o + 1;
          end
          if (m_tdata_i[7:2] !== want.irq_out) begin
            $error("irq_out mismatch: expected %0d, got %0d", want.irq_out, m_tdata_i[7:2]);
            fail_count_o = fail_count_o + 1;
          end
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        predicted_answers.push_back(resolve_irq_request(op_e'(s_tdata_i[1:0]),
                                                        s_tdata_i[8:2],
                                                        s_tdata_i[40:9],
                                                        s_tdata_i[72:41]));
      end
      pending_o = predicted_answers.size();
    end
  end

endmodule

// ----- sim/cascaded_interrupt_controller_tb.sv -----
module cascaded_interrupt_controller_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cic_pkg::*;

  // IRQ numbers at the edges of the secondary, primary and invalid ranges
  localparam logic [6:0]  IrqSecTop = 7'(SecSources - 1);
  localparam logic [6:0]  IrqPriLow = 7'(PriBase);
  localparam logic [6:0]  IrqPriAgg = 7'(PriBase + AggBit);
  localparam logic [6:0]  IrqPriTop = 7'(IrqCount - 1);
  localparam logic [6:0]  IrqBad    = 7'(IrqCount);
  localparam logic [6:0]  IrqMax    = 7'h7F;
  localparam logic [31:0] AllOnes   = 32'hFFFF_FFFF;

  localparam int RandomItems = 750;
  localparam int CalmItems   = 100;   // tail of the run without any idling
  localparam int DrainLimit  = 2000;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;

  logic quiet;          // suppress idling on both sides
  int   fail_count;
  int   pending;

  cascaded_interrupt_controller uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  cic_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_i   (s_axis_tready),
    .s_tdata_i    (s_axis_tdata),
    .m_tvalid_i   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .m_tdata_i    (m_axis_tdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs somewhere.
  initial begin
    #5ms;
    $display("FAIL cascaded_interrupt_controller");
    $finish;
  end

  // Answer side: hold tready low in random bursts, otherwise keep it high;
  // drop the stalls once the run goes quiet.
  initial begin : answer_sink
    int stall_left;
    stall_left = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 11) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Present one request item and hold it until the block takes it, then
  // maybe idle the request side for a burst. Leave tvalid high when no
  // gap follows so back-to-back items stream at full rate.
  task automatic send_request(input op_e op, input logic [6:0] irq,
                              input logic [31:0] lines, input logic [31:0] raise);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, raise, lines, irq, op};
    do @(posedge clk_i); while (!s_axis_tready);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
  endtask

  initial begin : stimulus
    int unsigned pick;
    op_e         op;
    logic [6:0]  irq;
    logic [31:0] lines;
    logic [31:0] raise;
    int          waited;

    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    quiet         = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part.
    // Right after reset: summary line enabled but every flag masked,
    // so an acknowledge drops the summary and finds nothing.
    send_request(OpAck, 7'd0, AllOnes, '0);
    send_request(OpAck, 7'd0, '0, '0);
    // Unmask the lowest and highest secondary sources, raise everything.
    send_request(OpEnable, 7'd0, '0, '0);
    send_request(OpEnable, IrqSecTop, '0, '0);
    send_request(OpUpdate, 7'd0, '0, AllOnes);
    // Acknowledge through the summary line: highest flag first, then the
    // lowest, then only masked flags remain.
    send_request(OpAck, 7'd0, AggMask, '0);
    send_request(OpAck, 7'd0, AggMask, '0);
    send_request(OpAck, 7'd0, AggMask, '0);
    // Primary sources at both ends of their range.
    send_request(OpEnable, IrqPriLow, '0, '0);
    send_request(OpEnable, IrqPriTop, '0, '0);
    send_request(OpAck, 7'd0, AllOnes, '0);
    send_request(OpDisable, IrqPriTop, '0, '0);
    send_request(OpAck, 7'd0, AllOnes, '0);
    // Out-of-range numbers: rejected, but the raised flags still stick.
    send_request(OpEnable, IrqBad, '0, '0);
    send_request(OpEnable, IrqMax, '0, 32'h8000_0001);
    send_request(OpDisable, IrqBad, '0, '0);
    send_request(OpDisable, IrqMax, '0, '0);
    send_request(OpAck, 7'd0, AggMask, '0);
    // Mask the summary line itself: pending secondary flags are hidden.
    send_request(OpDisable, 7'd0, '0, '0);
    send_request(OpDisable, IrqSecTop, '0, '0);
    send_request(OpDisable, IrqPriAgg, '0, '0);
    send_request(OpEnable, 7'd5, '0, 32'h0000_0020);
    send_request(OpAck, 7'd0, AllOnes, '0);
    send_request(OpEnable, IrqPriAgg, '0, '0);
    send_request(OpAck, 7'd0, AllOnes, '0);

    // Random part: mostly mask traffic and acknowledges with sparse line
    // and event patterns, so the priority encoders see varied winners and
    // the summary line sits among other pending primary lines.
    for (int n = 0; n < RandomItems; n++) begin
      quiet <= (n >= RandomItems - CalmItems);

      pick = $urandom_range(0, 99);
      if (pick < 30)      op = OpEnable;
      else if (pick < 45) op = OpDisable;
      else if (pick < 82) op = OpAck;
      else                op = OpUpdate;

      if ($urandom_range(0, 9) == 0) irq = 7'($urandom_range(IrqCount, 127));
      else                           irq = 7'($urandom_range(0, IrqCount - 1));

      case ($urandom_range(0, 5))
        0:       lines = $urandom;
        1:       lines = '0;
        2:       lines = AllOnes;
        default: lines = $urandom & $urandom & $urandom;
      endcase
      if ($urandom_range(0, 9) < 6) lines = lines | AggMask;

      case ($urandom_range(0, 19))
        0, 1, 2:       raise = $urandom;
        3, 4, 5, 6, 7: raise = 32'd1 << $urandom_range(0, 31);
        8, 9, 10:      raise = $urandom & $urandom & $urandom;
        default:       raise = '0;
      endcase

      send_request(op, irq, lines, raise);
    end
    s_axis_tvalid <= 1'b0;

    // Drain: wait for every predicted answer, then a few more cycles to
    // catch any stray answer item.
    waited = 0;
    while (pending != 0 && waited < DrainLimit) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (8) @(posedge clk_i);

    if (fail_count == 0 && pending == 0) begin
      $display("PASS cascaded_interrupt_controller");
    end else begin
      $display("FAIL cascaded_interrupt_controller");
    end
    $finish;
  end

endmodule
